FILE: hdl/ced_pkg.sv
// Shared types, codes and helpers for the case-insensitive edit distance unit.
`default_nettype none

package ced_pkg;

    localparam int MAX_LEN_DEF = 32;

    // request opcodes at the input port
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_TEXT  = 2'd2;
    localparam logic [1:0] OP_EMIT  = 2'd3;

    // command kinds travelling down the cell chain
    localparam logic [2:0] K_NOP   = 3'd0;
    localparam logic [2:0] K_START = 3'd1;
    localparam logic [2:0] K_LOAD  = 3'd2;
    localparam logic [2:0] K_TEXT  = 3'd3;
    localparam logic [2:0] K_EMIT  = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic       err;
        logic [7:0] ch;
    } t_cmd;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ced_ctrl.sv
// Front controller: decodes requests, tracks lengths and errors, feeds the cell chain.
`default_nettype none

module ced_ctrl
    import ced_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    localparam int IW = $clog2(MAX_LEN + 1),
    localparam int VW = $clog2(2 * MAX_LEN + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [1:0]    i_op,
    input  wire logic [7:0]    i_ch,
    output t_cmd               o_cmd,
    output logic [IW-1:0]      o_idx,
    output logic [VW-1:0]      o_left,
    output logic [VW-1:0]      o_diag
);

    localparam logic [IW-1:0] C_MAX = IW'(MAX_LEN);

    logic [IW-1:0] r_plen, n_plen;
    logic [IW-1:0] r_tcount, n_tcount;
    logic          r_tstarted, n_tstarted;
    logic          r_err, n_err;
    t_cmd          r_cmd, n_cmd;
    logic [IW-1:0] r_idx, n_idx;
    logic [VW-1:0] r_left, n_left;
    logic [VW-1:0] r_diag, n_diag;

    always_comb begin
        n_plen     = r_plen;
        n_tcount   = r_tcount;
        n_tstarted = r_tstarted;
        n_err      = r_err;
        n_cmd.kind = K_NOP;
        n_cmd.err  = r_err;
        n_cmd.ch   = i_ch;
        n_idx      = r_plen;
        // column entry zero: diag is the old top value, left the new one
        n_left     = VW'(r_tcount);
        n_diag     = VW'(r_tcount);
        if (i_start) begin
            unique case (i_op)
                OP_START: begin
                    n_plen     = '0;
                    n_tcount   = '0;
                    n_tstarted = 1'b0;
                    n_err      = 1'b0;
                    n_cmd.kind = K_START;
                end
                OP_LOAD: begin
                    if (r_tstarted || r_plen >= C_MAX) begin
                        n_err = 1'b1;
                    end else begin
                        n_cmd.kind = K_LOAD;
                        n_plen     = r_plen + 1'b1;
                    end
                end
                OP_TEXT: begin
                    n_tstarted = 1'b1;
                    if (r_tcount >= C_MAX) begin
                        n_err = 1'b1;
                    end else begin
                        n_cmd.kind = K_TEXT;
                        n_left     = VW'(r_tcount) + 1'b1;
                        n_tcount   = r_tcount + 1'b1;
                    end
                end
                OP_EMIT: begin
                    // left carries the result value; cells swap in their entry
                    n_cmd.kind = K_EMIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen     <= '0;
            r_tcount   <= '0;
            r_tstarted <= 1'b0;
            r_err      <= 1'b0;
            r_cmd.kind <= K_NOP;
            r_cmd.err  <= 1'b0;
            r_cmd.ch   <= '0;
        end else begin
            r_plen     <= n_plen;
            r_tcount   <= n_tcount;
            r_tstarted <= n_tstarted;
            r_err      <= n_err;
            r_cmd      <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_left <= n_left;
        r_diag <= n_diag;
    end

    assign o_cmd  = r_cmd;
    assign o_idx  = r_idx;
    assign o_left = r_left;
    assign o_diag = r_diag;

`ifndef SYNTHESIS
    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= C_MAX)
        else $error("pattern length beyond limit");

    a_tcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcount <= C_MAX)
        else $error("text count beyond limit");

    a_plen_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tstarted && !(i_start && i_op == OP_START) |=> $stable(r_plen))
        else $error("pattern grew after text started");
`endif

endmodule

`default_nettype wire

FILE: hdl/ced_cell.sv
// One systolic cell: holds one pattern byte and one dynamic programming entry.
`default_nettype none

module ced_cell
    import ced_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int POS = 0,
    localparam int IW = $clog2(MAX_LEN + 1),
    localparam int VW = $clog2(2 * MAX_LEN + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    input  wire logic [IW-1:0] i_idx,
    input  wire logic [VW-1:0] i_left,
    input  wire logic [VW-1:0] i_diag,
    output t_cmd               o_cmd,
    output logic [IW-1:0]      o_idx,
    output logic [VW-1:0]      o_left,
    output logic [VW-1:0]      o_diag
);

    localparam logic [IW-1:0] C_POS  = IW'(POS);
    localparam logic [IW-1:0] C_SLOT = IW'(POS + 1);
    localparam logic [VW-1:0] C_INIT = VW'(POS + 1);

    logic [7:0]    r_pat, n_pat;
    logic [VW-1:0] r_prev, n_prev;
    t_cmd          r_cmd;
    logic [IW-1:0] r_idx;
    logic [VW-1:0] r_left, n_left;
    logic [VW-1:0] r_diag, n_diag;

    logic          w_cost;
    logic [VW:0]   w_up, w_lf, w_dg, w_m1, w_best;

    always_comb begin
        w_cost = (r_pat != fold_case(i_cmd.ch));
        w_up   = {1'b0, r_prev} + 1'b1;
        w_lf   = {1'b0, i_left} + 1'b1;
        w_dg   = {1'b0, i_diag} + (VW + 1)'(w_cost);
        w_m1   = (w_lf < w_up) ? w_lf : w_up;
        w_best = (w_dg < w_m1) ? w_dg : w_m1;
    end

    always_comb begin
        n_pat  = r_pat;
        n_prev = r_prev;
        n_left = i_left;
        n_diag = i_diag;
        unique case (i_cmd.kind)
            K_START: n_prev = C_INIT;
            K_LOAD: begin
                if (i_idx == C_POS) begin
                    n_pat = fold_case(i_cmd.ch);
                end
            end
            K_TEXT: begin
                // bounded by 2*MAX_LEN, so the top bit is always clear
                n_prev = w_best[VW-1:0];
                n_left = w_best[VW-1:0];
                n_diag = r_prev;
            end
            K_EMIT: begin
                if (i_idx == C_SLOT) begin
                    n_left = r_prev;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= C_INIT;
            r_cmd.kind <= K_NOP;
            r_cmd.err  <= 1'b0;
            r_cmd.ch   <= '0;
        end else begin
            r_prev <= n_prev;
            r_cmd  <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat  <= n_pat;
        r_idx  <= i_idx;
        r_left <= n_left;
        r_diag <= n_diag;
    end

    assign o_cmd  = r_cmd;
    assign o_idx  = r_idx;
    assign o_left = r_left;
    assign o_diag = r_diag;

endmodule

`default_nettype wire

FILE: hdl/case_insensitive_edit_distance_unit.sv
// Top level: controller followed by a chain of MAX_LEN edit distance cells.
// Result path: an emit request is registered in the controller, then walks one cell per cycle down the chain,
//   and its result strobes at the output of the last cell.
// Throughput: one request per cycle; busy stays low, requests wavefront through the chain.
// Reset: synchronous active low; clears lengths, error flag and sets the column entry of cell k to k+1.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
`default_nettype none

module case_insensitive_edit_distance_unit
    import ced_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    localparam int IW = $clog2(MAX_LEN + 1),
    localparam int VW = $clog2(2 * MAX_LEN + 1)
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_ch,
    output logic            o_valid,
    output logic [5:0]      o_distance,
    output logic            o_error
);

    t_cmd          w_cmd  [0:MAX_LEN];
    logic [IW-1:0] w_idx  [0:MAX_LEN];
    logic [VW-1:0] w_left [0:MAX_LEN];
    logic [VW-1:0] w_diag [0:MAX_LEN];

    // every request enters the chain in order, so nothing ever waits
    assign busy = 1'b0;

    ced_ctrl #(
        .MAX_LEN(MAX_LEN)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start && !busy),
        .i_op    (i_op),
        .i_ch    (i_ch),
        .o_cmd   (w_cmd[0]),
        .o_idx   (w_idx[0]),
        .o_left  (w_left[0]),
        .o_diag  (w_diag[0])
    );

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        ced_cell #(
            .MAX_LEN(MAX_LEN),
            .POS    (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[k]),
            .i_idx   (w_idx[k]),
            .i_left  (w_left[k]),
            .i_diag  (w_diag[k]),
            .o_cmd   (w_cmd[k+1]),
            .o_idx   (w_idx[k+1]),
            .o_left  (w_left[k+1]),
            .o_diag  (w_diag[k+1])
        );
    end

    assign o_valid    = (w_cmd[MAX_LEN].kind == K_EMIT);
    assign o_error    = w_cmd[MAX_LEN].err;
    assign o_distance = w_cmd[MAX_LEN].err ? 6'd0 : 6'(w_left[MAX_LEN]);

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_cmd[0].kind == K_EMIT, MAX_LEN))
        else $error("result without matching emit request");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_distance == 6'd0)
        else $error("distance not cleared on error");

    a_left_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd[0].kind == K_TEXT |=> w_left[1] <= $past(w_left[0]) + 1)
        else $error("cell result exceeds left neighbor plus one");
`endif

endmodule

`default_nettype wire
